// ----- rtl/reed_solomon_parity_encoder_macros.svh -----
// Assertion macros shared by the Reed-Solomon parity encoder RTL.
`ifndef REED_SOLOMON_PARITY_ENCODER_MACROS_SVH
`define REED_SOLOMON_PARITY_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rsp_pkg.sv -----
// Package with GF(256) arithmetic, generator coefficients and shared types of the RS encoder.
package rsp_pkg;

    localparam int SYM_W      = 8;
    localparam int MAX_PARITY = 64;
    localparam logic [SYM_W:0] GF_POLY = 9'h11d;

    typedef logic [SYM_W-1:0] sym_t;

    // Control handed from the sequencer to every parity cell.
    typedef struct packed {
        logic en;
        sym_t fb;
    } ctrl_t;

    // GF(256) product, shift-and-add with reduction by the field polynomial.
    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        logic [SYM_W:0] x;
        sym_t           acc;
        x   = {1'b0, a};
        acc = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x[SYM_W-1:0];
            end
            x = {x[SYM_W-1:0], 1'b0};
            if (x[SYM_W]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

    // Coefficient idx of the generator polynomial with roots alpha^1 .. alpha^count.
    // Evaluated at elaboration only.
    function automatic sym_t gen_coef(input int count, input int idx);
        sym_t g [0:MAX_PARITY];
        sym_t root;
        for (int k = 0; k <= MAX_PARITY; k++) begin
            g[k] = '0;
        end
        g[0] = sym_t'(1);
        root = sym_t'(1);
        for (int i = 1; i <= MAX_PARITY; i++) begin
            if (i <= count) begin
                root = gf_mul(root, sym_t'(2));
                g[i] = sym_t'(1);
                for (int j = MAX_PARITY - 1; j > 0; j--) begin
                    if (j < i) begin
                        g[j] = g[j-1] ^ gf_mul(g[j], root);
                    end
                end
                g[0] = gf_mul(g[0], root);
            end
        end
        return g[idx];
    endfunction

endpackage

// ----- rtl/reed_solomon_parity_encoder.sv -----
// Output: a data symbol is registered and appears on the master side in the cycle after its request is accepted.
// Throughput: one symbol per cycle while m_tready does not stall the output; after the request marked tlast,
// PARITY_COUNT parity symbols follow, one per cycle under the same condition, with s_tready low. The drain length
// is set by the drain counter; the cell chain shifts out one entry per parity symbol sent.
// Reset: synchronous active-low aresetn clears the cells, the drain counter and m_tvalid.
`include "reed_solomon_parity_encoder_macros.svh"

module reed_solomon_parity_encoder #(
    parameter int PARITY_COUNT = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_symbol
    input  logic       s_tlast,   // end_of_block
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] code_symbol
    output logic       m_tuser,   // [0] is_parity
    output logic       m_tlast    // final_symbol
);
    import rsp_pkg::*;

    localparam int CNT_W = $clog2(PARITY_COUNT + 1);

    // Parity entries, entry 0 being the head of the shift register.
    sym_t  chain [0:PARITY_COUNT-1];
    ctrl_t ctrl;

    // Output register and drain counter.
    logic             m_valid_reg, m_valid_next;
    sym_t             m_data_reg,  m_data_next;
    logic             m_parity_reg, m_parity_next;
    logic             m_last_reg,  m_last_next;
    logic [CNT_W-1:0] drain_cnt_reg, drain_cnt_next;

    logic advance;
    logic draining;
    logic s_accept;
    logic chain_zero;

    // The output register can take a new symbol when it is empty or being emptied.
    assign advance  = !m_valid_reg || m_tready;
    assign draining = (drain_cnt_reg != '0);
    assign s_tready = advance && !draining;
    assign s_accept = s_tvalid && s_tready;

    // Each cell takes the entry of its upper neighbor XOR its coefficient times the feedback.
    // The top cell has nothing above it. During the parity drain the feedback is forced to
    // zero, which turns the chain into a plain shift register that empties itself.
    generate
        for (genvar j = 0; j < PARITY_COUNT; j++) begin : g_cell
            sym_t shift_in;
            if (j == PARITY_COUNT - 1) begin : g_top
                assign shift_in = '0;
            end else begin : g_mid
                assign shift_in = chain[j+1];
            end
            rsp_cell #(
                .COEF (gen_coef(PARITY_COUNT, PARITY_COUNT - 1 - j))
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .shift_in   (shift_in),
                .parity_out (chain[j])
            );
        end
    endgenerate

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_parity_next  = m_parity_reg;
        m_last_next    = m_last_reg;
        drain_cnt_next = drain_cnt_reg;
        ctrl.en        = 1'b0;
        ctrl.fb        = '0;
        if (s_accept) begin
            // Data symbol passes through while the cells absorb its feedback term.
            m_valid_next  = 1'b1;
            m_data_next   = s_tdata;
            m_parity_next = 1'b0;
            m_last_next   = 1'b0;
            ctrl.en       = 1'b1;
            ctrl.fb       = s_tdata ^ chain[0];
            if (s_tlast) begin
                drain_cnt_next = CNT_W'(PARITY_COUNT);
            end
        end else if (advance && draining) begin
            // Parity symbols leave head first; the last one carries tlast.
            m_valid_next   = 1'b1;
            m_data_next    = chain[0];
            m_parity_next  = 1'b1;
            m_last_next    = (drain_cnt_reg == CNT_W'(1));
            ctrl.en        = 1'b1;
            drain_cnt_next = drain_cnt_reg - CNT_W'(1);
        end else if (advance) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            drain_cnt_reg <= '0;
        end else begin
            m_valid_reg   <= m_valid_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_parity_reg <= m_parity_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_parity_reg;
    assign m_tlast  = m_last_reg;

    // True when every cell holds zero, as it must once a codeword is fully drained.
    always_comb begin
        chain_zero = 1'b1;
        for (int k = 0; k < PARITY_COUNT; k++) begin
            if (chain[k] != '0) begin
                chain_zero = 1'b0;
            end
        end
    end

    // A block end starts a drain of exactly PARITY_COUNT parity symbols.
    `RSP_ASSERT_NEXT(a_drain_start, aclk, aresetn, s_accept && s_tlast, drain_cnt_reg == CNT_W'(PARITY_COUNT), "drain did not start with full count")
    // When the final parity symbol is presented the cells are already clear for the next block.
    `RSP_ASSERT_NOW(a_chain_clear, aclk, aresetn, m_tvalid && m_tlast, chain_zero && !draining, "parity cells not clear at end of codeword")
    // The end of a codeword is always a parity symbol.
    `RSP_ASSERT_NOW(a_last_is_parity, aclk, aresetn, m_tvalid && m_tlast, m_tuser, "final symbol not marked as parity")

endmodule

// ----- rtl/rsp_cell.sv -----
// One parity cell: holds one register entry and takes its neighbor's entry plus a constant multiple of the feedback.
module rsp_cell #(
    parameter logic [7:0] COEF = 8'h01
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  rsp_pkg::ctrl_t ctrl,
    input  rsp_pkg::sym_t  shift_in,
    output rsp_pkg::sym_t  parity_out
);
    import rsp_pkg::*;

    sym_t parity_reg;
    sym_t parity_next;

    assign parity_next = shift_in ^ gf_mul(ctrl.fb, COEF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= '0;
        end else if (ctrl.en) begin
            parity_reg <= parity_next;
        end
    end

    assign parity_out = parity_reg;

endmodule
